/* rtl/sttc_pkg.sv */
package sttc_pkg;

   // angle and vector widths inside the rotation chain
   localparam int unsigned LaneWidth = 34;
   localparam int unsigned AtanLen   = 40;
   localparam int unsigned OutWidth  = 33;
   localparam int unsigned DefaultIterations = 24;

   // gain-compensated start value, Q4.30
   localparam logic signed [LaneWidth-1:0] CordicStart = 34'sd652032874;

   // register indexes of the control port
   typedef enum logic [1:0] {
      REG_REF_LAT  = 2'd0,
      REG_REF_LON  = 2'd1,
      REG_SELF_REF = 2'd2,
      REG_NONE     = 2'd3
   } reg_index_type;

   // atan(2^-i) in units of pi / 2^31
   localparam logic [31:0] ATAN_TAB [AtanLen] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0,
      32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
   };

   // one rotation lane: cos, sin and residual angle
   typedef struct packed {
      logic signed [LaneWidth-1:0] x;
      logic signed [LaneWidth-1:0] y;
      logic signed [LaneWidth-1:0] z;
   } lane_type;

   // lanes: point latitude, point longitude, site latitude, site longitude
   typedef struct packed {
      logic           valid;
      logic [31:0]    range;
      logic [3:0]     flip;
      lane_type [3:0] lane;
   } cell_type;

   // round a Q.30 product back to its scale
   function automatic logic signed [71:0] rnd30(input logic signed [71:0] p);
      return (p + 72'sd536870912) >>> 30;
   endfunction

endpackage

/* rtl/sttc_cordic_cell.sv */
module sttc_cordic_cell
   import sttc_pkg::*;
#(
   parameter int unsigned ITER = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  cell_type cell_in,
   output cell_type cell_out
);

   localparam logic signed [LaneWidth-1:0] Angle =
      LaneWidth'(signed'({1'b0, ATAN_TAB[ITER]}));

   cell_type cell_ff;
   cell_type cell_in_c;

   // one micro-rotation on each of the four lanes
   always_comb begin
      cell_in_c = cell_in;
      for (int k = 0; k < 4; k++) begin
         if (!cell_in.lane[k].z[LaneWidth-1]) begin
            cell_in_c.lane[k].x = cell_in.lane[k].x - (cell_in.lane[k].y >>> ITER);
            cell_in_c.lane[k].y = cell_in.lane[k].y + (cell_in.lane[k].x >>> ITER);
            cell_in_c.lane[k].z = cell_in.lane[k].z - Angle;
         end else begin
            cell_in_c.lane[k].x = cell_in.lane[k].x + (cell_in.lane[k].y >>> ITER);
            cell_in_c.lane[k].y = cell_in.lane[k].y - (cell_in.lane[k].x >>> ITER);
            cell_in_c.lane[k].z = cell_in.lane[k].z + Angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (advance) begin
         cell_ff <= cell_in_c;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* rtl/sttc_rotate.sv */
module sttc_rotate
   import sttc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  cell_type                   cell_in,
   output logic                       out_valid,
   output logic signed [OutWidth-1:0] north_out,
   output logic signed [OutWidth-1:0] up_out,
   output logic signed [OutWidth-1:0] east_out
);

   localparam logic signed [41:0] OutMax = 42'sd4294967295;
   localparam logic signed [41:0] OutMin = -42'sd4294967296;

   typedef logic signed [LaneWidth-1:0] q30_type;

   // stage 1: sign fold applied to sine and cosine
   logic s1_valid_ff;
   logic [31:0] s1_range_ff;
   q30_type s1_sin_ff [4];
   q30_type s1_cos_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_range_ff <= cell_in.range;
         for (int k = 0; k < 4; k++) begin
            s1_sin_ff[k] <= cell_in.flip[k] ? -cell_in.lane[k].y : cell_in.lane[k].y;
            s1_cos_ff[k] <= cell_in.flip[k] ? -cell_in.lane[k].x : cell_in.lane[k].x;
         end
      end
   end

   // stage 2: direction factors, z component and site coefficients
   logic s2_valid_ff;
   logic [31:0] s2_range_ff;
   q30_type s2_cc_ff, s2_cs_ff, s2_a1_ff, s2_a2_ff, s2_a3_ff, s2_a4_ff;
   q30_type s2_sp_ff, s2_cp_ff, s2_sl_ff, s2_cl_ff;
   logic signed [LaneWidth-1:0] s2_z_ff;
   logic signed [32:0] s1_r_c;

   assign s1_r_c = signed'({1'b0, s1_range_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_range_ff <= s1_range_ff;
         s2_cc_ff <= LaneWidth'(rnd30(72'(72'(s1_cos_ff[0]) * 72'(s1_cos_ff[1]))));
         s2_cs_ff <= LaneWidth'(rnd30(72'(72'(s1_cos_ff[0]) * 72'(s1_sin_ff[1]))));
         s2_z_ff  <= LaneWidth'(rnd30(72'(72'(s1_r_c) * 72'(s1_sin_ff[0]))));
         s2_a1_ff <= LaneWidth'(rnd30(72'(72'(s1_sin_ff[2]) * 72'(s1_cos_ff[3]))));
         s2_a2_ff <= LaneWidth'(rnd30(72'(72'(s1_sin_ff[2]) * 72'(s1_sin_ff[3]))));
         s2_a3_ff <= LaneWidth'(rnd30(72'(72'(s1_cos_ff[2]) * 72'(s1_cos_ff[3]))));
         s2_a4_ff <= LaneWidth'(rnd30(72'(72'(s1_cos_ff[2]) * 72'(s1_sin_ff[3]))));
         s2_sp_ff <= s1_sin_ff[2];
         s2_cp_ff <= s1_cos_ff[2];
         s2_sl_ff <= s1_sin_ff[3];
         s2_cl_ff <= s1_cos_ff[3];
      end
   end

   // stage 3: x and y components, negated coefficients
   logic s3_valid_ff;
   logic signed [LaneWidth-1:0] s3_x_ff, s3_y_ff, s3_z_ff;
   logic signed [LaneWidth:0] s3_n1_ff, s3_n2_ff, s3_u1_ff, s3_u2_ff;
   logic signed [LaneWidth:0] s3_cp_ff, s3_sp_ff, s3_e1_ff, s3_e2_ff;
   logic signed [32:0] s2_r_c;

   assign s2_r_c = signed'({1'b0, s2_range_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_x_ff  <= LaneWidth'(rnd30(72'(72'(s2_r_c) * 72'(s2_cc_ff))));
         s3_y_ff  <= LaneWidth'(rnd30(72'(72'(s2_r_c) * 72'(s2_cs_ff))));
         s3_z_ff  <= s2_z_ff;
         s3_n1_ff <= -(LaneWidth+1)'(s2_a1_ff);
         s3_n2_ff <= -(LaneWidth+1)'(s2_a2_ff);
         s3_u1_ff <= (LaneWidth+1)'(s2_a3_ff);
         s3_u2_ff <= (LaneWidth+1)'(s2_a4_ff);
         s3_cp_ff <= (LaneWidth+1)'(s2_cp_ff);
         s3_sp_ff <= (LaneWidth+1)'(s2_sp_ff);
         s3_e1_ff <= -(LaneWidth+1)'(s2_sl_ff);
         s3_e2_ff <= (LaneWidth+1)'(s2_cl_ff);
      end
   end

   // stage 4: eight rounded terms
   logic s4_valid_ff;
   logic signed [39:0] s4_t_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_t_ff[0] <= 40'(rnd30(72'(72'(s3_n1_ff) * 72'(s3_x_ff))));
         s4_t_ff[1] <= 40'(rnd30(72'(72'(s3_n2_ff) * 72'(s3_y_ff))));
         s4_t_ff[2] <= 40'(rnd30(72'(72'(s3_cp_ff) * 72'(s3_z_ff))));
         s4_t_ff[3] <= 40'(rnd30(72'(72'(s3_u1_ff) * 72'(s3_x_ff))));
         s4_t_ff[4] <= 40'(rnd30(72'(72'(s3_u2_ff) * 72'(s3_y_ff))));
         s4_t_ff[5] <= 40'(rnd30(72'(72'(s3_sp_ff) * 72'(s3_z_ff))));
         s4_t_ff[6] <= 40'(rnd30(72'(72'(s3_e1_ff) * 72'(s3_x_ff))));
         s4_t_ff[7] <= 40'(rnd30(72'(72'(s3_e2_ff) * 72'(s3_y_ff))));
      end
   end

   // stage 5: sums with saturation into the output register
   logic signed [41:0] sum_n_c, sum_u_c, sum_e_c;
   logic out_valid_ff;
   logic signed [OutWidth-1:0] north_ff, up_ff, east_ff;

   function automatic logic signed [OutWidth-1:0] sat(input logic signed [41:0] v);
      if (v > OutMax) begin
         return OutWidth'(OutMax);
      end else if (v < OutMin) begin
         return OutWidth'(OutMin);
      end
      return OutWidth'(v);
   endfunction

   assign sum_n_c = 42'(s4_t_ff[0]) + 42'(s4_t_ff[1]) + 42'(s4_t_ff[2]);
   assign sum_u_c = 42'(s4_t_ff[3]) + 42'(s4_t_ff[4]) + 42'(s4_t_ff[5]);
   assign sum_e_c = 42'(s4_t_ff[6]) + 42'(s4_t_ff[7]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         north_ff <= sat(sum_n_c);
         up_ff    <= sat(sum_u_c);
         east_ff  <= sat(sum_e_c);
      end
   end

   assign out_valid = out_valid_ff;
   assign north_out = north_ff;
   assign up_out    = up_ff;
   assign east_out  = east_ff;

endmodule

/* rtl/spherical_to_topocentric.sv */
// channel    direction   fields
// req_       in          range_in, latitude_in, longitude_in
// rsp_       out         north_out, up_out, east_out
// csr_       in/out      ref_latitude @0, ref_longitude @4, self_reference @8
//
// one point per cycle unless a result is held; CORDIC_ITERATIONS (at most 40)
// rotation cells, then five stages: sign fold, three multiply stages and the sum
// the whole pipeline moves together; it holds while a result waits under rsp_stall
// synchronous reset clears valid flags and the three registers
module spherical_to_topocentric
   import sttc_pkg::*;
#(
   parameter int unsigned CORDIC_ITERATIONS = DefaultIterations
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [31:0]                req_range_in,
   input  logic signed [31:0]         req_latitude_in,
   input  logic signed [31:0]         req_longitude_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OutWidth-1:0] rsp_north_out,
   output logic signed [OutWidth-1:0] rsp_up_out,
   output logic signed [OutWidth-1:0] rsp_east_out,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [3:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned NumCells =
      (CORDIC_ITERATIONS > AtanLen) ? AtanLen : CORDIC_ITERATIONS;

   // control registers
   logic [31:0] ref_lat_ff, ref_lon_ff;
   logic        self_ref_ff;
   logic        csr_write_c;
   reg_index_type csr_index_c;

   assign csr_pready  = 1'b1;
   assign csr_write_c = csr_psel && csr_penable && csr_pwrite;
   assign csr_index_c = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lat_ff  <= '0;
         ref_lon_ff  <= '0;
         self_ref_ff <= 1'b0;
      end else if (csr_write_c) begin
         case (csr_index_c)
            REG_REF_LAT:  ref_lat_ff  <= csr_pwdata;
            REG_REF_LON:  ref_lon_ff  <= csr_pwdata;
            REG_SELF_REF: self_ref_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index_c)
         REG_REF_LAT:  csr_prdata = ref_lat_ff;
         REG_REF_LON:  csr_prdata = ref_lon_ff;
         REG_SELF_REF: csr_prdata = {31'd0, self_ref_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // pipeline moves unless a finished result is held
   logic advance_c;
   assign advance_c = !(rsp_valid && rsp_stall);
   assign req_stall = !advance_c;

   // load: fold each angle into the right half plane
   logic [31:0] ang_c [4];
   cell_type    chain [NumCells+1];

   assign ang_c[0] = req_latitude_in;
   assign ang_c[1] = req_longitude_in;
   assign ang_c[2] = self_ref_ff ? req_latitude_in : ref_lat_ff;
   assign ang_c[3] = self_ref_ff ? req_longitude_in : ref_lon_ff;

   always_comb begin
      chain[0].valid = req_valid;
      chain[0].range = req_range_in;
      for (int k = 0; k < 4; k++) begin
         chain[0].flip[k]    = ang_c[k][31] ^ ang_c[k][30];
         chain[0].lane[k].x  = CordicStart;
         chain[0].lane[k].y  = '0;
         chain[0].lane[k].z  = LaneWidth'(signed'({ang_c[k][31] ^ chain[0].flip[k],
                                                    ang_c[k][30:0]}));
      end
   end

   // row of rotation cells
   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      sttc_cordic_cell #(.ITER(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance_c),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   // products, site rotation and saturation
   sttc_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance_c),
      .cell_in   (chain[NumCells]),
      .out_valid (rsp_valid),
      .north_out (rsp_north_out),
      .up_out    (rsp_up_out),
      .east_out  (rsp_east_out)
   );

`ifndef SYNTHESIS
   // input is only held back by a waiting result
   assert property (@(posedge clock) req_stall |-> rsp_valid)
      else $error("input stalled without a held result");

   // self reference bit follows a write to its register
   assert property (@(posedge clock) disable iff (reset)
      csr_write_c && csr_index_c == REG_SELF_REF |=> self_ref_ff == $past(csr_pwdata[0]))
      else $error("self reference write lost");

   // a held result does not move the pipeline
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_north_out))
      else $error("held result changed");
`endif

endmodule

/* sim/sttc_checker.sv */
`timescale 1ns / 1ps

module sttc_checker
   import sttc_pkg::*;
#(
   parameter int unsigned CORDIC_ITERATIONS = DefaultIterations
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [31:0]                req_range_in,
   input  logic signed [31:0]         req_latitude_in,
   input  logic signed [31:0]         req_longitude_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [OutWidth-1:0] rsp_north_out,
   input  logic signed [OutWidth-1:0] rsp_up_out,
   input  logic signed [OutWidth-1:0] rsp_east_out,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [3:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   input  logic                       csr_pready,
   output int                         fail_count,
   output int                         pending_count
);

   typedef struct {
      logic signed [OutWidth-1:0] north;
      logic signed [OutWidth-1:0] up;
      logic signed [OutWidth-1:0] east;
   } enu_type;

   enu_type     enu_queue[$];
   logic [31:0] site_lat;
   logic [31:0] site_lon;
   logic        use_own_angles;

   // cordic sine and cosine, q2.30
   function automatic void sin_cos(input logic [31:0] ang, output longint s,
                                   output longint c);
      logic   flip;
      longint x, y, z, dx, dy;
      flip = ang[31] ^ ang[30];
      z = flip ? longint'($signed(ang + 32'h8000_0000)) : longint'($signed(ang));
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_ITERATIONS && i < AtanLen; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint round30(input longint p);
      return (p + 64'sd536870912) >>> 30;
   endfunction

   function automatic logic signed [OutWidth-1:0] clamp(input longint v);
      if (v > 64'sd4294967295) return 33'sh0_FFFF_FFFF;
      if (v < -64'sd4294967296) return 33'sh1_0000_0000;
      return v[OutWidth-1:0];
   endfunction

   // expected local vector of one point
   function automatic enu_type predict_enu(input logic [31:0] r, input logic [31:0] lat,
                                           input logic [31:0] lon);
      longint sla, cla, slo, clo, sp, cp, sl, cl, rr, xc, yc, zc, n, u, e;
      logic [31:0] p0, l0;
      enu_type res;
      p0 = use_own_angles ? lat : site_lat;
      l0 = use_own_angles ? lon : site_lon;
      sin_cos(lat, sla, cla);
      sin_cos(lon, slo, clo);
      sin_cos(p0, sp, cp);
      sin_cos(l0, sl, cl);
      rr = longint'(r);
      xc = round30(rr * round30(cla * clo));
      yc = round30(rr * round30(cla * slo));
      zc = round30(rr * sla);
      n = round30(-round30(sp * cl) * xc) + round30(-round30(sp * sl) * yc)
          + round30(cp * zc);
      u = round30(round30(cp * cl) * xc) + round30(round30(cp * sl) * yc)
          + round30(sp * zc);
      e = round30(-sl * xc) + round30(cl * yc);
      res.north = clamp(n);
      res.up = clamp(u);
      res.east = clamp(e);
      return res;
   endfunction

   task automatic report(input string what, input logic signed [OutWidth-1:0] got,
                         input logic signed [OutWidth-1:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending_count = enu_queue.size();

   initial fail_count = 0;

   // watch register writes, input and result transfers
   always @(posedge clock) begin
      enu_type want;
      if (reset) begin
         site_lat <= '0;
         site_lon <= '0;
         use_own_angles <= 1'b0;
         enu_queue.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_REF_LAT:  site_lat <= csr_pwdata;
               REG_REF_LON:  site_lon <= csr_pwdata;
               REG_SELF_REF: use_own_angles <= csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            enu_queue.push_back(predict_enu(req_range_in, req_latitude_in, req_longitude_in));
         if (rsp_valid && !rsp_stall) begin
            if (enu_queue.size() == 0) begin
               $display("unexpected result transfer at %0t", $realtime);
               fail_count++;
            end else begin
               want = enu_queue.pop_front();
               if (rsp_north_out !== want.north) report("north", rsp_north_out, want.north);
               if (rsp_up_out !== want.up) report("up", rsp_up_out, want.up);
               if (rsp_east_out !== want.east) report("east", rsp_east_out, want.east);
            end
         end
      end
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import sttc_pkg::*;

   localparam int Latency = 60;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [31:0]                req_range_in;
   logic signed [31:0]         req_latitude_in;
   logic signed [31:0]         req_longitude_in;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [OutWidth-1:0] rsp_north_out;
   logic signed [OutWidth-1:0] rsp_up_out;
   logic signed [OutWidth-1:0] rsp_east_out;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [3:0]                 csr_paddr;
   logic [31:0]                csr_pwdata;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;
   int                         fail_count;
   int                         pending_count;
   bit                         quiet_tail;
   bit                         hold_long;

   spherical_to_topocentric u_top (.*);

   sttc_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("[spherical_to_topocentric] ERROR");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            hold_long = 1'b0;
         end
         if (!quiet_tail && $urandom_range(3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(7, 1)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge clock);
         end
      end
   end

   task automatic reg_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // one input transfer, random gaps ahead of it
   task automatic send_point(input logic [31:0] r, input logic [31:0] lat,
                             input logic [31:0] lon);
      if (!quiet_tail && $urandom_range(5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(7, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_range_in <= r;
      req_latitude_in <= lat;
      req_longitude_in <= lon;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (Latency) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_angle();
      case ($urandom_range(4))
         0: return {$urandom_range(3) << 30} + 32'($urandom_range(3)) - 32'd1;
         1: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_range();
      case ($urandom_range(3))
         0: return 32'hFFFF_FFFF - $urandom_range(255);
         1: return $urandom_range(65535);
         default: return $urandom;
      endcase
   endfunction

   logic [31:0] site_angles [4] = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h4000_0000};

   initial begin
      req_valid = 1'b0;
      req_range_in = '0;
      req_latitude_in = '0;
      req_longitude_in = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      quiet_tail = 1'b0;
      hold_long = 1'b0;
      reset = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners at reset settings
      send_point(32'h0, 32'h0, 32'h0);
      send_point(32'hFFFF_FFFF, 32'h0, 32'h0);
      send_point(32'hFFFF_FFFF, 32'h4000_0000, 32'h0);
      send_point(32'hFFFF_FFFF, 32'hC000_0000, 32'h8000_0000);
      send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000);
      send_point(32'h100, 32'h2000_0000, 32'hE000_0000);
      send_point(32'hFFFF_FFFF, 32'h2000_0000, 32'h2000_0000);
      drain();
      // overflow corners with a tilted site
      reg_write(REG_REF_LAT, 32'hE000_0000);
      reg_write(REG_REF_LON, 32'h2000_0000);
      reg_write(REG_NONE, 32'hFFFF_FFFF);
      send_point(32'hFFFF_FFFF, 32'h1000_0000, 32'h2000_0000);
      send_point(32'hFFFF_FFFF, 32'hF000_0000, 32'hE000_0000);
      send_point(32'hFFFF_FFFF, 32'h0, 32'h6000_0000);
      drain();
      reg_write(REG_SELF_REF, 32'h1);
      send_point(32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0);
      send_point(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
      drain();

      // random phases over several site settings
      for (int ph = 0; ph < 8; ph++) begin
         reg_write(REG_REF_LAT, ph < 4 ? site_angles[ph] : $urandom);
         reg_write(REG_REF_LON, ph < 4 ? site_angles[3 - ph] : $urandom);
         reg_write(REG_SELF_REF, 32'(ph == 5 || ph == 7));
         if (ph == 2) begin
            hold_long = 1'b1;
         end
         if (ph == 7) quiet_tail = 1'b1;
         for (int k = 0; k < 205; k++)
            send_point(rand_range(), rand_angle(), rand_angle());
         drain();
      end

      if (fail_count == 0) begin
         $display("[spherical_to_topocentric] OK");
      end else begin
         $display("[spherical_to_topocentric] ERROR");
      end
      $finish;
   end

endmodule
